[design/act_pkg.sv]
// ----------------------------------------------------------------------------
// act_pkg
// Shared types, constants and fixed-point helpers of the adaptive
// computed-torque servo step.
// ----------------------------------------------------------------------------
package act_pkg;

   localparam int NUM_AXES   = 3;
   localparam int FRAC_BITS  = 16;
   localparam int WORD_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int ACC_W      = 36;
   localparam int SMP_WORDS  = 5;
   localparam int DIV_STEPS  = WORD_W + FRAC_BITS;
   localparam int DVD_W      = WORD_W + FRAC_BITS;
   localparam int W_DEPTH    = 111;
   localparam int WADDR_W    = 7;
   localparam int MASS_BASE  = 0;
   localparam int VEL_BASE   = 45;
   localparam int GRAV_BASE  = 99;
   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] MASS_LAST = 3'd4;
   localparam logic [2:0] VEL_LAST  = 3'd5;
   localparam logic [2:0] GRAV_LAST = 3'd3;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   // register indexes
   localparam logic [2:0] REG_MASS_GAIN = 3'd0;
   localparam logic [2:0] REG_VEL_GAIN  = 3'd1;
   localparam logic [2:0] REG_GRAV_GAIN = 3'd2;
   localparam logic [2:0] REG_PERIOD    = 3'd3;
   localparam logic [2:0] REG_TRAIN     = 3'd4;

   typedef struct packed {
      logic [1:0]         axis_index;
      logic signed [31:0] time_remaining;
      logic signed [31:0] target_pos;
      logic signed [31:0] target_vel;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } req_type;

   typedef struct packed {
      logic [1:0]         torque_axis;
      logic signed [31:0] torque;
      logic               divide_fault;
      logic               last_torque;
   } rsp_type;

   typedef enum logic [1:0] {SET_MASS, SET_VEL, SET_GRAV} set_type;

   typedef enum logic [3:0] {
      M_ACC_PER, M_P2P2, M_P2V2, M_TMP_V0, M_P2V0, M_W_PH,
      M_SUM_ACC, M_SUM_PV, M_ERR_ACC, M_ERR_VEL, M_GAIN_PH, M_TMP_F
   } mul_sel_type;

   typedef enum logic [3:0] {
      W_NONE, W_PV, W_PHM4, W_TMP, W_PHV4, W_PHV5, W_SUM, W_TAU,
      W_MM, W_MV, W_UPD, W_GADD, W_Q1, W_ACC
   } wr_sel_type;

   typedef enum logic {D_FIRST, D_SECOND} div_sel_type;

   typedef struct packed {
      logic               tick_start;
      logic               div_start;
      div_sel_type        div_sel;
      mul_sel_type        msel;
      wr_sel_type         wsel;
      logic               w_cap;
      logic               out_load;
      logic               last;
      logic [WADDR_W-1:0] addr;
      logic [1:0]         k;
      logic [1:0]         l;
      logic [2:0]         j;
      set_type            set;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
      else if (v < 64'shffff_ffff_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat36(input logic signed [ACC_W-1:0] v);
      return sat64(64'(v));
   endfunction

   // product of two Q values: floor shift, then saturate
   function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
      return sat64(p >>> FRAC_BITS);
   endfunction

endpackage

[design/adaptive_computed_torque_step.sv]
// ----------------------------------------------------------------------------
// adaptive_computed_torque_step
// Adaptive computed-torque servo step for a three-axis arm, Q16.16.
// ----------------------------------------------------------------------------
// Send one sample item per axis; samples for axes 0 and 1 are stored, and the
// item for axis 2 starts a servo tick that returns three torque items in axis
// order. While the tick runs, req_stall stays high. A tick runs six divisions
// through the one-bit-per-cycle divider, the torque sums and, with training on,
// the weight updates, all through one shared multiplier and the single-port
// weight memory (one weight read or written per access). The last torque item
// may sit in the output register while new samples come in. Write the
// configuration registers over the csr_ port only while no tick runs; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module adaptive_computed_torque_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  act_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output act_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [act_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import act_pkg::*;

   logic [30:0] mass_gain_ff, vel_gain_ff, grav_gain_ff, period_ff;
   logic        train_ff;
   logic        busy, accept, csr_wr;
   logic [2:0]  csr_idx;
   cmd_type     cmd;
   status_type  stat;

   assign req_stall  = busy;
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_gain_ff <= 31'd164;
         vel_gain_ff  <= 31'd164;
         grav_gain_ff <= 31'd65536;
         period_ff    <= 31'd3277;
         train_ff     <= 1'b1;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MASS_GAIN: mass_gain_ff <= csr_pwdata[30:0];
            REG_VEL_GAIN:  vel_gain_ff  <= csr_pwdata[30:0];
            REG_GRAV_GAIN: grav_gain_ff <= csr_pwdata[30:0];
            REG_PERIOD:    period_ff    <= csr_pwdata[30:0];
            REG_TRAIN:     train_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MASS_GAIN: csr_prdata = {1'b0, mass_gain_ff};
         REG_VEL_GAIN:  csr_prdata = {1'b0, vel_gain_ff};
         REG_GRAV_GAIN: csr_prdata = {1'b0, grav_gain_ff};
         REG_PERIOD:    csr_prdata = {1'b0, period_ff};
         REG_TRAIN:     csr_prdata = {31'd0, train_ff};
         default:       csr_prdata = '0;
      endcase
   end

   act_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .tick_go  (accept && req_data.axis_index == AXIS_LAST),
      .train_en (train_ff),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // drop samples for the unused axis code
   act_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .smp_we    (accept && req_data.axis_index <= AXIS_LAST),
      .smp       (req_data),
      .mass_gain (mass_gain_ff),
      .vel_gain  (vel_gain_ff),
      .grav_gain (grav_gain_ff),
      .period    (period_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

[design/act_ram.sv]
// ----------------------------------------------------------------------------
// act_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module act_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

[design/act_div.sv]
// ----------------------------------------------------------------------------
// act_div
// Q-format divider: (num << FRAC_BITS) / den, one quotient bit per cycle,
// truncated toward zero and saturated; a divisor not above zero flags fault and saturates by the sign of num.
// ----------------------------------------------------------------------------
module act_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic signed [31:0] quo,
   output logic               fault
);
   import act_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic                     busy_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [DVD_W-1:0]         dvd_ff;
   logic [WORD_W-1:0]        rem_ff;
   logic [WORD_W-1:0]        den_ff;
   logic                     neg_ff;
   logic                     fault_ff;
   logic signed [31:0]       spec_ff;
   logic [WORD_W:0]          trial;
   logic                     fit;
   logic [WORD_W-1:0]        mag;
   logic signed [63:0]       signed_q;

   assign mag   = num[31] ? WORD_W'(-num) : WORD_W'(num);
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fit   = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= den > 32'sd0;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
      if (start) begin
         fault_ff <= den <= 32'sd0;
         if (num > 32'sd0) spec_ff <= 32'sh7fff_ffff;
         else if (num < 32'sd0) spec_ff <= 32'sh8000_0000;
         else spec_ff <= '0;
         neg_ff <= num[31];
         dvd_ff <= {mag, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         den_ff <= WORD_W'(den);
         cnt_ff <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         // shift quotient bits in where dividend bits leave
         rem_ff <= fit ? WORD_W'(trial - {1'b0, den_ff}) : trial[WORD_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], fit};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign signed_q = neg_ff ? -64'(dvd_ff) : 64'(dvd_ff);
   assign quo      = fault_ff ? spec_ff : sat64(signed_q);
   assign busy     = busy_ff;
   assign fault    = fault_ff;
endmodule

[design/act_dp.sv]
// ----------------------------------------------------------------------------
// act_dp
// Datapath: sample buffer, tick registers, shared multiplier, divider,
// weight memory with valid bits and the result register.
// ----------------------------------------------------------------------------
module act_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  act_pkg::cmd_type       cmd,
   output act_pkg::status_type    stat,
   input  logic                   smp_we,
   input  act_pkg::req_type       smp,
   input  logic [30:0]            mass_gain,
   input  logic [30:0]            vel_gain,
   input  logic [30:0]            grav_gain,
   input  logic [30:0]            period,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output act_pkg::rsp_type       rsp_data
);
   import act_pkg::*;

   logic signed [31:0]      sb_ff [NUM_AXES][SMP_WORDS];
   logic signed [31:0]      pv_ff [NUM_AXES];
   logic signed [31:0]      acc_ff [NUM_AXES];
   logic signed [31:0]      err_ff [NUM_AXES];
   logic signed [31:0]      q1_ff, phm4_ff, phv4_ff, phv5_ff, tmp_ff, mm_ff, mv_ff, w_ff;
   logic signed [ACC_W-1:0] sum_ff, tau_ff;
   logic signed [63:0]      prod_ff;
   logic                    fault_ff;
   logic [W_DEPTH-1:0]      vld_ff;
   logic                    vrd_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic signed [31:0]      ma, mb, q, phi, gain, factor, wd, div_num;
   logic signed [31:0]      tr, tp, tv, ps, vl, p0, p1, p2, v0, v2;
   logic signed [31:0]      dquo, diff, upd;
   logic signed [ACC_W-1:0] wide;
   logic                    dbusy, dfault, ram_we;
   logic [WORD_W-1:0]       rdata;

   assign tr = sb_ff[cmd.k][0];
   assign tp = sb_ff[cmd.k][1];
   assign tv = sb_ff[cmd.k][2];
   assign ps = sb_ff[cmd.k][3];
   assign vl = sb_ff[cmd.k][4];
   assign p0 = sb_ff[0][3];
   assign p1 = sb_ff[1][3];
   assign p2 = sb_ff[2][3];
   assign v0 = sb_ff[0][4];
   assign v2 = sb_ff[2][4];
   assign q  = qfix(prod_ff);
   assign wd = vrd_ff ? signed'(rdata) : 32'sd0;

   always_comb begin
      case (cmd.j)
         3'd0:    phi = ONE_Q;
         3'd1:    phi = p0;
         3'd2:    phi = p1;
         3'd3:    phi = p2;
         3'd4:    phi = (cmd.set == SET_VEL) ? phv4_ff : phm4_ff;
         default: phi = phv5_ff;
      endcase
      case (cmd.set)
         SET_MASS: begin gain = {1'b0, mass_gain}; factor = mm_ff; end
         SET_VEL:  begin gain = {1'b0, vel_gain};  factor = mv_ff; end
         default:  begin gain = {1'b0, grav_gain}; factor = err_ff[cmd.k]; end
      endcase
   end

   always_comb begin
      case (cmd.msel)
         M_ACC_PER: begin ma = acc_ff[cmd.k];  mb = {1'b0, period}; end
         M_P2P2:    begin ma = p2;             mb = p2; end
         M_P2V2:    begin ma = p2;             mb = v2; end
         M_TMP_V0:  begin ma = tmp_ff;         mb = v0; end
         M_P2V0:    begin ma = p2;             mb = v0; end
         M_W_PH:    begin ma = wd;             mb = phi; end
         M_SUM_ACC: begin ma = sat36(sum_ff);  mb = acc_ff[cmd.l]; end
         M_SUM_PV:  begin ma = sat36(sum_ff);  mb = pv_ff[cmd.l]; end
         M_ERR_ACC: begin ma = err_ff[cmd.k];  mb = acc_ff[cmd.l]; end
         M_ERR_VEL: begin ma = err_ff[cmd.k];  mb = sb_ff[cmd.l][4]; end
         M_GAIN_PH: begin ma = gain;           mb = phi; end
         default:   begin ma = tmp_ff;         mb = factor; end
      endcase
   end

   always_comb begin
      if (cmd.div_sel == D_FIRST) begin
         diff    = sat36(ACC_W'(tp) - ACC_W'(ps));
         wide    = ACC_W'(diff) + (ACC_W'(diff) <<< 1);
         div_num = sat36(wide);
      end else begin
         diff    = '0;
         wide    = ACC_W'(q1_ff) - (ACC_W'(vl) <<< 1) - ACC_W'(tv);
         div_num = sat36(wide);
      end
   end

   act_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (tr),
      .busy  (dbusy),
      .quo   (dquo),
      .fault (dfault)
   );

   assign ram_we = cmd.wsel == W_UPD;
   assign upd    = sat36(ACC_W'(w_ff) + ACC_W'(q));

   act_ram #(.WIDTH(WORD_W), .DEPTH(W_DEPTH)) u_wram (
      .clock (clock),
      .we    (ram_we),
      .addr  (cmd.addr),
      .wdata (WORD_W'(upd)),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (smp_we) begin
         sb_ff[smp.axis_index][0] <= smp.time_remaining;
         sb_ff[smp.axis_index][1] <= smp.target_pos;
         sb_ff[smp.axis_index][2] <= smp.target_vel;
         sb_ff[smp.axis_index][3] <= smp.position;
         sb_ff[smp.axis_index][4] <= smp.velocity;
      end
      prod_ff <= 64'(ma) * 64'(mb);
      vrd_ff  <= vld_ff[cmd.addr];
      if (cmd.w_cap) w_ff <= wd;
      case (cmd.wsel)
         W_PHM4:  phm4_ff <= q;
         W_TMP:   tmp_ff  <= q;
         W_PHV4:  phv4_ff <= q;
         W_PHV5:  phv5_ff <= q;
         W_MM:    mm_ff   <= q;
         W_MV:    mv_ff   <= q;
         W_Q1:    q1_ff   <= dquo;
         W_ACC: begin
            acc_ff[cmd.k] <= sat36(ACC_W'(dquo) <<< 1);
            err_ff[cmd.k] <= sat36(ACC_W'(pv_ff[cmd.k]) - ACC_W'(vl));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) pv_ff[i] <= '0;
         vld_ff       <= '0;
         fault_ff     <= 1'b0;
         sum_ff       <= '0;
         tau_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wsel == W_PV) pv_ff[cmd.k] <= sat36(ACC_W'(vl) + ACC_W'(q));
         if (ram_we) vld_ff[cmd.addr] <= 1'b1;
         if (cmd.tick_start) begin
            fault_ff <= 1'b0;
            sum_ff   <= '0;
            tau_ff   <= '0;
         end else begin
            if ((cmd.wsel == W_Q1 || cmd.wsel == W_ACC) && dfault) fault_ff <= 1'b1;
            case (cmd.wsel)
               W_SUM:  sum_ff <= sum_ff + ACC_W'(q);
               W_TAU: begin
                  tau_ff <= tau_ff + ACC_W'(q);
                  sum_ff <= '0;
               end
               W_GADD: begin
                  tau_ff <= tau_ff + ACC_W'(sat36(sum_ff));
                  sum_ff <= '0;
               end
               default: ;
            endcase
            if (cmd.out_load) tau_ff <= '0;
         end
         // hold the item until taken
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.torque_axis  <= cmd.k;
         rsp_ff.torque       <= sat36(tau_ff);
         rsp_ff.divide_fault <= fault_ff;
         rsp_ff.last_torque  <= cmd.last;
      end
   end

   assign stat.div_busy = dbusy;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
endmodule

[design/act_ctrl.sv]
// ----------------------------------------------------------------------------
// act_ctrl
// Tick sequencer: walks the axis divisions, feature products, torque sums
// and weight updates, one datapath command per cycle, waiting on a busy divider or a held output.
// ----------------------------------------------------------------------------
module act_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_go,
   input  logic                 train_en,
   input  act_pkg::status_type  stat,
   output act_pkg::cmd_type     cmd,
   output logic                 busy
);
   import act_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_D1_GO, S_D1_WT, S_D1_WR, S_D2_GO, S_D2_WT, S_D2_WR,
      S_PV_MUL, S_PV_WR, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
      S_T_RD, S_T_MUL, S_T_ACC, S_T_PMUL, S_T_PACC, S_T_GADD, S_T_OUT,
      S_U_ROW, S_U_MM, S_U_MV, S_U_RD, S_U_T, S_U_M2, S_U_WR
   } state_type;

   state_type  state_ff;
   logic [1:0] k_ff, l_ff;
   logic [2:0] j_ff;
   set_type    set_ff;
   logic [2:0] jlast;
   logic [3:0] row;
   logic       jend;

   assign row  = {k_ff, 1'b0} + 4'(k_ff) + 4'(l_ff);
   assign jend = j_ff == jlast;

   always_comb begin
      case (set_ff)
         SET_MASS: jlast = MASS_LAST;
         SET_VEL:  jlast = VEL_LAST;
         default:  jlast = GRAV_LAST;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.msel       = M_ACC_PER;
      cmd.wsel       = W_NONE;
      cmd.div_sel    = D_FIRST;
      cmd.k          = k_ff;
      cmd.l          = l_ff;
      cmd.j          = j_ff;
      cmd.set        = set_ff;
      case (set_ff)
         SET_MASS: cmd.addr = WADDR_W'(MASS_BASE) + WADDR_W'({row, 2'b00})
                              + WADDR_W'(row) + WADDR_W'(j_ff);
         SET_VEL:  cmd.addr = WADDR_W'(VEL_BASE) + WADDR_W'({row, 2'b00})
                              + WADDR_W'({row, 1'b0}) + WADDR_W'(j_ff);
         default:  cmd.addr = WADDR_W'(GRAV_BASE) + WADDR_W'({k_ff, 2'b00})
                              + WADDR_W'(j_ff);
      endcase
      case (state_ff)
         S_IDLE:   cmd.tick_start = tick_go;
         S_D1_GO:  cmd.div_start = 1'b1;
         S_D1_WR:  cmd.wsel = W_Q1;
         S_D2_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = D_SECOND;
         end
         S_D2_WT:  cmd.div_sel = D_SECOND;
         S_D2_WR:  cmd.wsel = W_ACC;
         S_PV_MUL: cmd.msel = M_ACC_PER;
         S_PV_WR:  cmd.wsel = W_PV;
         S_F1:     cmd.msel = M_P2P2;
         S_F2: begin cmd.wsel = W_PHM4; cmd.msel = M_P2V2; end
         S_F3:     cmd.wsel = W_TMP;
         S_F4:     cmd.msel = M_TMP_V0;
         S_F5: begin cmd.wsel = W_PHV4; cmd.msel = M_P2V0; end
         S_F6:     cmd.wsel = W_TMP;
         S_F7:     cmd.msel = M_TMP_V0;
         S_F8:     cmd.wsel = W_PHV5;
         S_T_MUL:  cmd.msel = M_W_PH;
         S_T_ACC:  cmd.wsel = W_SUM;
         S_T_PMUL: cmd.msel = (set_ff == SET_MASS) ? M_SUM_ACC : M_SUM_PV;
         S_T_PACC: cmd.wsel = W_TAU;
         S_T_GADD: cmd.wsel = W_GADD;
         S_T_OUT: begin
            cmd.out_load = stat.out_free;
            cmd.last     = k_ff == AXIS_LAST;
         end
         S_U_ROW:  cmd.msel = M_ERR_ACC;
         S_U_MM: begin cmd.wsel = W_MM; cmd.msel = M_ERR_VEL; end
         S_U_MV:   cmd.wsel = W_MV;
         S_U_RD:   cmd.msel = M_GAIN_PH;
         S_U_T: begin cmd.w_cap = 1'b1; cmd.wsel = W_TMP; end
         S_U_M2:   cmd.msel = M_TMP_F;
         S_U_WR:   cmd.wsel = W_UPD;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         l_ff     <= '0;
         j_ff     <= '0;
         set_ff   <= SET_MASS;
      end else begin
         case (state_ff)
            S_IDLE: if (tick_go) begin
               k_ff     <= '0;
               state_ff <= S_D1_GO;
            end
            S_D1_GO:  state_ff <= S_D1_WT;
            S_D1_WT:  if (!stat.div_busy) state_ff <= S_D1_WR;
            S_D1_WR:  state_ff <= S_D2_GO;
            S_D2_GO:  state_ff <= S_D2_WT;
            S_D2_WT:  if (!stat.div_busy) state_ff <= S_D2_WR;
            S_D2_WR:  state_ff <= S_PV_MUL;
            S_PV_MUL: state_ff <= S_PV_WR;
            S_PV_WR: if (k_ff == AXIS_LAST) begin
               k_ff     <= '0;
               state_ff <= S_F1;
            end else begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_D1_GO;
            end
            S_F1: state_ff <= S_F2;
            S_F2: state_ff <= S_F3;
            S_F3: state_ff <= S_F4;
            S_F4: state_ff <= S_F5;
            S_F5: state_ff <= S_F6;
            S_F6: state_ff <= S_F7;
            S_F7: state_ff <= S_F8;
            S_F8: begin
               l_ff     <= '0;
               j_ff     <= '0;
               set_ff   <= SET_MASS;
               state_ff <= S_T_RD;
            end
            S_T_RD:  state_ff <= S_T_MUL;
            S_T_MUL: state_ff <= S_T_ACC;
            S_T_ACC: if (jend) begin
               j_ff     <= '0;
               state_ff <= (set_ff == SET_GRAV) ? S_T_GADD : S_T_PMUL;
            end else begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_T_RD;
            end
            S_T_PMUL: state_ff <= S_T_PACC;
            S_T_PACC: begin
               state_ff <= S_T_RD;
               if (set_ff == SET_MASS) begin
                  set_ff <= SET_VEL;
               end else if (l_ff == AXIS_LAST) begin
                  l_ff   <= '0;
                  set_ff <= SET_GRAV;
               end else begin
                  l_ff   <= l_ff + 1'b1;
                  set_ff <= SET_MASS;
               end
            end
            S_T_GADD: state_ff <= S_T_OUT;
            S_T_OUT: if (stat.out_free) begin
               set_ff <= SET_MASS;
               if (k_ff == AXIS_LAST) begin
                  k_ff     <= '0;
                  l_ff     <= '0;
                  state_ff <= train_en ? S_U_ROW : S_IDLE;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_T_RD;
               end
            end
            S_U_ROW: state_ff <= S_U_MM;
            S_U_MM:  state_ff <= S_U_MV;
            S_U_MV:  state_ff <= S_U_RD;
            S_U_RD:  state_ff <= S_U_T;
            S_U_T:   state_ff <= S_U_M2;
            S_U_M2:  state_ff <= S_U_WR;
            S_U_WR: if (!jend) begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_U_RD;
            end else begin
               j_ff <= '0;
               case (set_ff)
                  SET_MASS: begin
                     set_ff   <= SET_VEL;
                     state_ff <= S_U_RD;
                  end
                  SET_VEL: if (k_ff == AXIS_LAST && l_ff == AXIS_LAST) begin
                     k_ff     <= '0;
                     l_ff     <= '0;
                     set_ff   <= SET_GRAV;
                     state_ff <= S_U_RD;
                  end else begin
                     if (l_ff == AXIS_LAST) begin
                        l_ff <= '0;
                        k_ff <= k_ff + 1'b1;
                     end else begin
                        l_ff <= l_ff + 1'b1;
                     end
                     set_ff   <= SET_MASS;
                     state_ff <= S_U_ROW;
                  end
                  default: if (k_ff == AXIS_LAST) begin
                     k_ff     <= '0;
                     set_ff   <= SET_MASS;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_U_RD;
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = state_ff != S_IDLE;
endmodule

[tb/tb_adaptive_computed_torque_step.sv]
// ----------------------------------------------------------------------------
// tb_adaptive_computed_torque_step
// Self-checking bench for the adaptive computed-torque servo step. Axis
// samples go in over the req_ channel. A fixed-point torque predictor with
// its own weights works out the three torques of every tick. Torques are
// checked field by field in order. The run changes gains, servo period and
// training between phases, and the sender and receiver idle at random.
// ----------------------------------------------------------------------------
import act_pkg::*;

class torque_scoreboard;
   int smp[3][5];
   int proj_vel[3];
   int mass_w[9][5];
   int vel_w[9][6];
   int grav_w[3][4];
   int mass_gain, vel_gain, grav_gain, period;
   bit train_on;
   rsp_type torque_q[$];
   int errors, ticks, faults, torques_seen;

   function new();
      foreach (smp[i, j]) smp[i][j] = 0;
      foreach (proj_vel[i]) proj_vel[i] = 0;
      foreach (mass_w[i, j]) mass_w[i][j] = 0;
      foreach (vel_w[i, j]) vel_w[i][j] = 0;
      foreach (grav_w[i, j]) grav_w[i][j] = 0;
      mass_gain = 164; vel_gain = 164; grav_gain = 65536; period = 3277;
      train_on = 1;
   endfunction

   function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function int fmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat(p >>> FRAC_BITS);
   endfunction

   function int fdiv(int a, int b, ref bit flt);
      if (b <= 0) begin
         flt = 1;
         if (a > 0) return 32'sh7fffffff;
         if (a < 0) return 32'sh80000000;
         return 0;
      end
      return sat((longint'(a) <<< FRAC_BITS) / longint'(b));
   endfunction

   function void set_reg(int idx, logic [31:0] val);
      case (idx)
         REG_MASS_GAIN: mass_gain = int'(val & 32'h7fffffff);
         REG_VEL_GAIN:  vel_gain  = int'(val & 32'h7fffffff);
         REG_GRAV_GAIN: grav_gain = int'(val & 32'h7fffffff);
         REG_PERIOD:    period    = int'(val & 32'h7fffffff);
         REG_TRAIN:     train_on  = val[0];
         default: ;
      endcase
   endfunction

   // buffer the sample; axis 2 runs the tick
   function void note_sample(req_type d);
      int acc[3], err[3], pos[3], vel[3];
      int phm[5], phv[6], phg[4];
      int q1, inner, mm, mv;
      longint tau, g, ms, vs;
      bit flt;
      rsp_type r;
      flt = 0;
      if (d.axis_index == 2'd3) return;
      smp[d.axis_index] = '{d.time_remaining, d.target_pos, d.target_vel,
                            d.position, d.velocity};
      if (d.axis_index != AXIS_LAST) return;
      ticks++;
      for (int i = 0; i < 3; i++) begin
         pos[i] = smp[i][3];
         vel[i] = smp[i][4];
         q1 = fdiv(sat(3 * longint'(sat(longint'(smp[i][1]) - pos[i]))), smp[i][0], flt);
         inner = sat(longint'(q1) - 2 * longint'(vel[i]) - longint'(smp[i][2]));
         acc[i] = sat(2 * longint'(fdiv(inner, smp[i][0], flt)));
      end
      for (int i = 0; i < 3; i++) begin
         err[i] = sat(longint'(proj_vel[i]) - vel[i]);
         proj_vel[i] = sat(longint'(vel[i]) + fmul(acc[i], period));
      end
      phm = '{ONE_Q, pos[0], pos[1], pos[2], fmul(pos[2], pos[2])};
      phv = '{ONE_Q, pos[0], pos[1], pos[2], fmul(fmul(pos[2], vel[2]), vel[0]),
              fmul(fmul(pos[2], vel[0]), vel[0])};
      phg = '{ONE_Q, pos[0], pos[1], pos[2]};
      if (flt) faults++;
      for (int k = 0; k < 3; k++) begin
         tau = 0; g = 0;
         for (int l = 0; l < 3; l++) begin
            ms = 0; vs = 0;
            for (int j = 0; j < 5; j++) ms += fmul(mass_w[3*k+l][j], phm[j]);
            for (int j = 0; j < 6; j++) vs += fmul(vel_w[3*k+l][j], phv[j]);
            tau += fmul(sat(ms), acc[l]);
            tau += fmul(sat(vs), proj_vel[l]);
         end
         for (int j = 0; j < 4; j++) g += fmul(grav_w[k][j], phg[j]);
         tau += sat(g);
         r.torque_axis = k[1:0];
         r.torque = sat(tau);
         r.divide_fault = flt;
         r.last_torque = (k == 2);
         torque_q.push_back(r);
      end
      if (train_on) begin
         for (int i = 0; i < 9; i++) begin
            mm = fmul(err[i/3], acc[i%3]);
            mv = fmul(err[i/3], vel[i%3]);
            for (int j = 0; j < 5; j++)
               mass_w[i][j] = sat(longint'(mass_w[i][j]) + fmul(fmul(mass_gain, phm[j]), mm));
            for (int j = 0; j < 6; j++)
               vel_w[i][j] = sat(longint'(vel_w[i][j]) + fmul(fmul(vel_gain, phv[j]), mv));
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++)
               grav_w[i][j] = sat(longint'(grav_w[i][j]) +
                                  fmul(fmul(grav_gain, phg[j]), err[i]));
      end
   endfunction

   function void check_torque(rsp_type a);
      rsp_type e;
      torques_seen++;
      if (torque_q.size() == 0) begin
         $display("%0t: unexpected torque item %h", $time, a);
         errors++;
         return;
      end
      e = torque_q.pop_front();
      if (a.torque_axis !== e.torque_axis) begin
         $display("%0t: torque_axis expected %0d actual %0d", $time, e.torque_axis,
                  a.torque_axis);
         errors++;
      end
      if (a.torque !== e.torque) begin
         $display("%0t: torque expected %h actual %h", $time, e.torque, a.torque);
         errors++;
      end
      if (a.divide_fault !== e.divide_fault) begin
         $display("%0t: divide_fault expected %b actual %b", $time, e.divide_fault,
                  a.divide_fault);
         errors++;
      end
      if (a.last_torque !== e.last_torque) begin
         $display("%0t: last_torque expected %b actual %b", $time, e.last_torque,
                  a.last_torque);
         errors++;
      end
   endfunction
endclass

module tb_adaptive_computed_torque_step;
   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   torque_scoreboard sb;
   int send_idle_pct, rx_stall_pct;
   bit hold_req;
   int hold_cnt;

   adaptive_computed_torque_step dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 0;
      hold_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_cnt = 3000;
            hold_req = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1;
         end else
            rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_torque(rsp_data);
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_sample(input req_type d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 0;
         req_data <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      @(negedge clock);
      req_valid <= 1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      sb.note_sample(d);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hffffffff;
            endcase
         end
         default: return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
      endcase
   endfunction

   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return pick_word();
         default: return $urandom_range(32'h800, 32'h40000);
      endcase
   endfunction

   function automatic req_type make_sample(input logic [1:0] ax);
      req_type d;
      d.axis_index = ax;
      d.time_remaining = pick_time();
      d.target_pos = pick_word();
      d.target_vel = pick_word();
      d.position = pick_word();
      d.velocity = pick_word();
      return d;
   endfunction

   task automatic send_tick();
      for (int a = 0; a < 3; a++) send_sample(make_sample(a[1:0]));
   endtask

   task automatic drain();
      while (sb.torque_q.size() > 0) @(posedge clock);
      // weight updates may still run after the last torque
      repeat (1500) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] mg, vg, gg, per, tr);
      // drop the last sample so it is not taken again while idle
      @(negedge clock);
      req_valid <= 0;
      drain();
      csr_write(REG_MASS_GAIN, mg);
      csr_write(REG_VEL_GAIN, vg);
      csr_write(REG_GRAV_GAIN, gg);
      csr_write(REG_PERIOD, per);
      csr_write(REG_TRAIN, tr);
   endtask

   initial begin
      req_type d;
      sb = new();
      reset = 1;
      req_valid = 0; req_data = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 0; rx_stall_pct = 0; hold_req = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: plain tick, extremes, non-positive time, ignored axis
      send_tick();
      d = make_sample(2'd3);
      send_sample(d);
      for (int a = 0; a < 3; a++) begin
         d = '{a[1:0], 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h7fffffff};
         send_sample(d);
      end
      for (int a = 0; a < 3; a++) begin
         d = '{a[1:0], 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h80000000};
         send_sample(d);
      end
      for (int a = 0; a < 3; a++) begin
         d = make_sample(a[1:0]);
         d.time_remaining = (a == 1) ? 32'h0 : 32'hffff0000;
         d.target_pos = d.position;
         send_sample(d);
      end
      d = '{2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
      send_sample(d);
      send_tick();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
            1: configure(0, 0, 0, 0, 0);
            2: configure(3000, 500, 80000, 3277, 1);
            3: configure(164, 164, 65536, 6554, 0);
            4: configure($urandom, $urandom, $urandom, $urandom, 1);
            default: configure(164, 164, 65536, 3277, 1);
         endcase
         if (ph == 2) csr_write(3'd5, $urandom);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin send_idle_pct = 51; rx_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rx_stall_pct = 51; end
            default: begin send_idle_pct = 16; rx_stall_pct = 16; end
         endcase
         if (ph == 4) hold_req = 1;
         for (int n = 0; n < 8; n++) begin
            if ($urandom_range(0, 4) == 0)
               // noise: random axis order, ignored axis included
               repeat ($urandom_range(1, 3))
                  send_sample(make_sample(2'($urandom_range(0, 3))));
            else
               send_tick();
         end
      end

      @(negedge clock);
      req_valid <= 0;
      drain();
      $display("Ran %0d servo ticks (%0d with divide faults), checked %0d torques.",
               sb.ticks, sb.faults, sb.torques_seen);
      $display("Covered gain and period extremes, training on and off, idle and stall mixes.");
      if (sb.errors == 0 && sb.torque_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

[files.f]
design/act_pkg.sv
design/act_ram.sv
design/act_div.sv
design/act_dp.sv
design/act_ctrl.sv
design/adaptive_computed_torque_step.sv
tb/tb_adaptive_computed_torque_step.sv
